// ===== rtl/core/pfe_pkg.sv =====
`default_nettype none

package pfe_pkg;

  localparam logic [2:0] OP_WRITE     = 3'd0;
  localparam logic [2:0] OP_SET_LEVEL = 3'd1;
  localparam logic [2:0] OP_FADE_OUT  = 3'd2;
  localparam logic [2:0] OP_FADE_IN   = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  localparam logic [3:0] LEVEL_MAX = 4'd8;
  localparam logic [4:0] CH_MAX    = 5'd31;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_OUT  = 2'd1;
  localparam logic [1:0] MODE_IN   = 2'd2;

  typedef struct packed {
    logic apply;
    logic busy;
  } fade_evt_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfe_ram.sv =====
`default_nettype none

module pfe_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfe_blend.sv =====
`default_nettype none

module pfe_blend (
  input  wire logic [14:0] color_i,
  input  wire logic [3:0]  level_i,
  input  wire logic        white_i,
  output logic      [14:0] color_o
);
  import pfe_pkg::*;

  always_comb begin
    logic [4:0] ch;
    logic [4:0] span;
    logic [8:0] prod;
    logic [4:0] delta;
    color_o = '0;
    for (int k = 0; k < 3; k++) begin
      ch    = color_i[k*5 +: 5];
      span  = white_i ? (CH_MAX - ch) : ch;
      prod  = 9'(span) * 9'(level_i);
      delta = prod[7:3];
      color_o[k*5 +: 5] = white_i ? (ch + delta) : (ch - delta);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pfe_fade_ctrl.sv =====
`default_nettype none

module pfe_fade_ctrl (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [2:0] operation_i,
  input  wire logic [3:0] new_level_i,
  input  wire logic [7:0] frames_per_step_i,
  input  wire logic       to_white_i,
  output logic      [3:0] level_o,
  output logic            white_o,
  output pfe_pkg::fade_evt_t evt_o
);
  import pfe_pkg::*;

  logic [3:0] level_q, level_d;
  logic       white_q, white_d;
  logic [1:0] mode_q, mode_d;
  logic [3:0] step_q, step_d;
  logic [7:0] frame_q, frame_d;
  logic [7:0] frames_q, frames_d;

  always_comb begin
    logic [3:0] step_nx;
    logic [7:0] frame_nx;
    level_d    = level_q;
    white_d    = white_q;
    mode_d     = mode_q;
    step_d     = step_q;
    frame_d    = frame_q;
    frames_d   = frames_q;
    evt_o      = '0;
    step_nx    = step_q + 4'd1;
    frame_nx   = frame_q - 8'd1;
    if (acc_i) begin
      unique case (operation_i)
        OP_SET_LEVEL: begin
          level_d     = (new_level_i > LEVEL_MAX) ? LEVEL_MAX : new_level_i;
          mode_d      = MODE_IDLE;
          step_d      = '0;
          frame_d     = '0;
          evt_o.apply = 1'b1;
        end
        OP_FADE_OUT, OP_FADE_IN: begin
          white_d  = to_white_i;
          frames_d = (frames_per_step_i == 8'd0) ? 8'd1 : frames_per_step_i;
          mode_d   = (operation_i == OP_FADE_OUT) ? MODE_OUT : MODE_IN;
          step_d   = '0;
          frame_d  = '0;
        end
        OP_TICK: begin
          if (mode_q != MODE_IDLE) begin
            if (frame_q != 8'd0 || step_q >= LEVEL_MAX) begin
              if (frame_q != 8'd0) begin
                frame_d = frame_nx;
              end
              if (frame_d == 8'd0 && step_q >= LEVEL_MAX) begin
                mode_d = MODE_IDLE;
              end
            end else begin
              step_d  = step_nx;
              level_d = (mode_q == MODE_OUT) ? step_nx : (LEVEL_MAX - step_nx);
              frame_d = frames_q - 8'd1;
              if (step_nx >= LEVEL_MAX && frame_d == 8'd0) begin
                mode_d = MODE_IDLE;
              end
              evt_o.apply = 1'b1;
              evt_o.busy  = (mode_d != MODE_IDLE);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LEVEL_MAX;
      white_q  <= 1'b0;
      mode_q   <= MODE_IDLE;
      step_q   <= '0;
      frame_q  <= '0;
      frames_q <= 8'd1;
    end else begin
      level_q  <= level_d;
      white_q  <= white_d;
      mode_q   <= mode_d;
      step_q   <= step_d;
      frame_q  <= frame_d;
      frames_q <= frames_d;
    end
  end

  assign level_o = level_q;
  assign white_o = white_q;

endmodule

`default_nettype wire

// ===== rtl/core/palette_fade_engine.sv =====
`default_nettype none

// Palette fade engine. Each transaction is a palette write, a level change, a fade start or a
// vsync tick. A write, a fade start and any tick that does not step the level produce no output.
// A level change, and a tick that steps a started fade, produce one output transaction per
// palette entry in index order, one per cycle unless the output stalls, through the single
// blend unit fed by the palette RAM's registered read port. in_ready_o stays low while the
// entries are issued and read, so the next transaction waits for the run; output back-pressure
// stretches the run. The palette reads as zero until an entry is written.
module palette_fade_engine #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [5:0]  entry_index_i,
  input  wire logic [14:0] entry_color_i,
  input  wire logic [3:0]  new_level_i,
  input  wire logic [7:0]  frames_per_step_i,
  input  wire logic        to_white_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [5:0]  out_index_o,
  output logic      [14:0] out_color_o,
  output logic             last_entry_o,
  output logic             fade_busy_o
);
  import pfe_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                       state_q, state_d;
  logic [IDX_W-1:0]           issue_q, issue_d;
  logic                       busy_q, busy_d;
  logic [PALETTE_ENTRIES-1:0] valid_q;

  logic             s1_vld_q;
  logic             s1_ok_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_last_q;

  logic        out_vld_q;
  logic [5:0]  out_idx_q;
  logic [14:0] out_col_q;
  logic        out_last_q;
  logic        out_busy_q;

  logic             acc;
  logic             adv;
  logic             issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W+5:0] wr_wide;
  logic [IDX_W+5:0] rd_wide;
  logic [14:0]      ram_rdata;
  logic [14:0]      src_color;
  logic [14:0]      blend_color;
  logic [3:0]       level;
  logic             white;
  fade_evt_t        evt;

  assign in_ready_o = (state_q == ST_IDLE) && !s1_vld_q;
  assign acc        = in_valid_i && in_ready_o;
  assign adv        = !out_vld_q || out_ready_i;
  assign issue      = (state_q == ST_WALK) && adv;

  assign wr_wide = {{IDX_W{1'b0}}, entry_index_i};
  assign wr_addr = wr_wide[IDX_W-1:0];
  assign wr_en   = acc && (operation_i == OP_WRITE)
                   && (32'(entry_index_i) < 32'(PALETTE_ENTRIES));

  assign rd_wide = {6'b0, s1_idx_q};

  pfe_fade_ctrl u_fade_ctrl (
    .clk_i,
    .rst_ni,
    .acc_i             (acc),
    .operation_i,
    .new_level_i,
    .frames_per_step_i,
    .to_white_i,
    .level_o           (level),
    .white_o           (white),
    .evt_o             (evt)
  );

  pfe_ram #(
    .WIDTH (15),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk_i,
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (entry_color_i),
    .re_i    (issue),
    .raddr_i (issue_q),
    .rdata_o (ram_rdata)
  );

  assign src_color = s1_ok_q ? ram_rdata : '0;

  pfe_blend u_blend (
    .color_i (src_color),
    .level_i (level),
    .white_i (white),
    .color_o (blend_color)
  );

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    busy_d  = busy_q;
    unique case (state_q)
      ST_IDLE: begin
        if (evt.apply) begin
          state_d = ST_WALK;
          issue_d = '0;
          busy_d  = evt.busy;
        end
      end
      ST_WALK: begin
        if (adv) begin
          issue_d = issue_q + 1'b1;
          if (issue_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= '0;
      busy_q    <= 1'b0;
      valid_q   <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      busy_q  <= busy_d;
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (adv) begin
        s1_vld_q  <= issue;
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_ok_q   <= valid_q[issue_q];
      s1_idx_q  <= issue_q;
      s1_last_q <= (issue_q == LAST_IDX);
    end
    if (adv && s1_vld_q) begin
      out_idx_q  <= rd_wide[5:0];
      out_col_q  <= blend_color;
      out_last_q <= s1_last_q;
      out_busy_q <= busy_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_index_o  = out_idx_q;
  assign out_color_o  = out_col_q;
  assign last_entry_o = out_last_q;
  assign fade_busy_o  = out_busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/pfe_checker.sv =====
`default_nettype none

module pfe_checker #(
  parameter int PALETTE_ENTRIES = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [2:0]  operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [5:0]  out_index_o,
  input wire logic        last_entry_o,
  input wire logic        fade_busy_o
);
  import pfe_pkg::*;

  logic out_mid;
  assign out_mid = out_valid_o && out_ready_i && !last_entry_o;

  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mid |=> out_valid_o)
    else $error("gap inside an apply run");

  a_run_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mid |=> out_index_o == $past(out_index_o) + 6'd1)
    else $error("apply run index not consecutive");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_entry_o |-> out_index_o == 6'(PALETTE_ENTRIES - 1))
    else $error("last entry flag on wrong index");

  a_busy_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_mid |=> fade_busy_o == $past(fade_busy_o))
    else $error("fade busy changed within a run");

  a_set_level_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OP_SET_LEVEL |=> !in_ready_o)
    else $error("ready after set level transaction");

endmodule

bind palette_fade_engine pfe_checker #(
  .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_pfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .operation_i  (operation_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_index_o  (out_index_o),
  .last_entry_o (last_entry_o),
  .fade_busy_o  (fade_busy_o)
);

`default_nettype wire

// ===== verif/palette_fade_engine_test.sv =====
`timescale 1ns / 100ps

module palette_fade_engine_test;
  import pfe_pkg::*;

  localparam int N_ENTRIES     = 64;
  localparam int RESET_CYCLES  = 12;
  localparam int TARGET_ITEMS  = 155;
  localparam int CALM_ITEMS    = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int END_DRAIN     = N_ENTRIES + 16;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [14:0] col;
    logic [3:0]  lvl;
    logic [7:0]  fps;
    logic        tw;
    bit          drain_first;
    bit          hold_rx;
    bit          calm;
  } palette_txn_t;

  typedef struct {
    logic [5:0]  index;
    logic [14:0] color;
    logic        last;
    logic        busy;
  } entry_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  operation_i;
  logic [5:0]  entry_index_i;
  logic [14:0] entry_color_i;
  logic [3:0]  new_level_i;
  logic [7:0]  frames_per_step_i;
  logic        to_white_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [5:0]  out_index_o;
  logic [14:0] out_color_o;
  logic        last_entry_o;
  logic        fade_busy_o;

  // shadow of the block's state
  logic [14:0] pal_shadow [N_ENTRIES];
  logic [3:0]  lvl_shadow;
  logic        white_shadow;
  logic [1:0]  mode_shadow;
  logic [3:0]  steps_taken;
  logic [7:0]  ticks_left;
  logic [7:0]  ticks_per_level;

  palette_txn_t  pending_txns [$];
  entry_result_t expected_entries [$];
  palette_txn_t  cur_txn;
  entry_result_t want;

  bit tag_drain, tag_hold, tag_calm;
  bit in_accepted, rx_hold_req, calm_mode;
  int send_gap, rx_gap, hold_left;
  int n_items_in, n_results, n_runs, n_errors, n_cycles;
  int kind, nw, nt;
  logic [7:0] fps_pick;

  palette_fade_engine DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .entry_index_i     (entry_index_i),
    .entry_color_i     (entry_color_i),
    .new_level_i       (new_level_i),
    .frames_per_step_i (frames_per_step_i),
    .to_white_i        (to_white_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_index_o       (out_index_o),
    .out_color_o       (out_color_o),
    .last_entry_o      (last_entry_o),
    .fade_busy_o       (fade_busy_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [4:0] fade_channel(input logic [4:0] c, input logic [3:0] s,
                                              input logic w);
    int cv;
    int sv;
    cv = int'(c);
    sv = int'(s);
    if (w) return 5'(cv + (((int'(CH_MAX) - cv) * sv) >> 3));
    return 5'(cv - ((cv * sv) >> 3));
  endfunction

  function automatic logic [14:0] blend_rgb555(input logic [14:0] col, input logic [3:0] s,
                                               input logic w);
    if (s == 4'd0) return col;
    return {fade_channel(col[14:10], s, w), fade_channel(col[9:5], s, w),
            fade_channel(col[4:0], s, w)};
  endfunction

  task automatic queue_palette_run(input logic busy);
    entry_result_t r;
    for (int i = 0; i < N_ENTRIES; i++) begin
      r.index = 6'(i);
      r.color = blend_rgb555(pal_shadow[i], lvl_shadow, white_shadow);
      r.last  = (i == N_ENTRIES - 1);
      r.busy  = busy;
      expected_entries.push_back(r);
    end
  endtask

  task automatic predict_fade(input palette_txn_t t);
    unique case (t.op)
      OP_WRITE: begin
        pal_shadow[t.idx] = t.col;
      end
      OP_SET_LEVEL: begin
        lvl_shadow  = (t.lvl > LEVEL_MAX) ? LEVEL_MAX : t.lvl;
        mode_shadow = MODE_IDLE;
        steps_taken = 4'd0;
        ticks_left  = 8'd0;
        queue_palette_run(1'b0);
      end
      OP_FADE_OUT, OP_FADE_IN: begin
        white_shadow    = t.tw;
        ticks_per_level = (t.fps == 8'd0) ? 8'd1 : t.fps;
        mode_shadow     = (t.op == OP_FADE_OUT) ? MODE_OUT : MODE_IN;
        steps_taken     = 4'd0;
        ticks_left      = 8'd0;
      end
      OP_TICK: begin
        if (mode_shadow != MODE_IDLE) begin
          if (ticks_left != 8'd0 || steps_taken >= LEVEL_MAX) begin
            if (ticks_left != 8'd0) ticks_left--;
            if (ticks_left == 8'd0 && steps_taken >= LEVEL_MAX) mode_shadow = MODE_IDLE;
          end else begin
            steps_taken++;
            lvl_shadow = (mode_shadow == MODE_OUT) ? steps_taken : LEVEL_MAX - steps_taken;
            ticks_left = ticks_per_level - 8'd1;
            if (steps_taken >= LEVEL_MAX && ticks_left == 8'd0) mode_shadow = MODE_IDLE;
            queue_palette_run(mode_shadow != MODE_IDLE);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [14:0] exp_v,
                             input logic [14:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      n_errors++;
    end
  endtask

  task push_txn(input logic [2:0] op, input logic [5:0] idx, input logic [14:0] col,
                input logic [3:0] lvl, input logic [7:0] fps, input logic tw);
    palette_txn_t t;
    t.op = op;
    t.idx = idx;
    t.col = col;
    t.lvl = lvl;
    t.fps = fps;
    t.tw = tw;
    t.drain_first = tag_drain;
    t.hold_rx = tag_hold;
    t.calm = tag_calm;
    pending_txns.push_back(t);
    tag_drain = 1'b0;
    tag_hold = 1'b0;
  endtask

  task push_rand(input logic [2:0] op);
    push_txn(op, 6'($urandom), 15'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // driver: presents the next transaction once the previous one was taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      in_accepted = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_txns.size() != 0 &&
                   !(pending_txns[0].drain_first && expected_entries.size() != 0)) begin
        cur_txn = pending_txns.pop_front();
        operation_i       <= cur_txn.op;
        entry_index_i     <= cur_txn.idx;
        entry_color_i     <= cur_txn.col;
        new_level_i       <= cur_txn.lvl;
        frames_per_step_i <= cur_txn.fps;
        to_white_i        <= cur_txn.tw;
        in_valid_i        <= 1'b1;
        if (!cur_txn.calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm_mode && $urandom_range(0, 15) == 0) rx_gap = $urandom_range(1, 11);
      end
    end
  end

  // monitor: checks output transactions, feeds accepted inputs to the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_entries.size() == 0) begin
          $error("unexpected output transaction: index %0d color %0d", out_index_o,
                 out_color_o);
          n_errors++;
        end else begin
          want = expected_entries.pop_front();
          check_field("out_index", 15'(want.index), 15'(out_index_o));
          check_field("out_color", want.color, out_color_o);
          check_field("last_entry", 15'(want.last), 15'(last_entry_o));
          check_field("fade_busy", 15'(want.busy), 15'(fade_busy_o));
          if (want.last) n_runs++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_fade(cur_txn);
        n_items_in++;
        in_accepted = 1'b1;
        calm_mode = cur_txn.calm;
        if (cur_txn.hold_rx) rx_hold_req = 1'b1;
      end
    end
  end

  initial begin
    n_cycles = 0;
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("Timeout with %0d entries still expected", expected_entries.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    operation_i = OP_WRITE;
    entry_index_i = '0;
    entry_color_i = '0;
    new_level_i = '0;
    frames_per_step_i = '0;
    to_white_i = 1'b0;
    for (int i = 0; i < N_ENTRIES; i++) pal_shadow[i] = '0;
    lvl_shadow = LEVEL_MAX;
    white_shadow = 1'b0;
    mode_shadow = MODE_IDLE;
    steps_taken = '0;
    ticks_left = '0;
    ticks_per_level = 8'd1;

    // directed part
    push_rand(OP_TICK);
    push_rand(OP_SPARE_FIRST);
    push_rand(3'(OP_SPARE_FIRST + 3'd1));
    push_rand(OP_SPARE_LAST);
    push_txn(OP_WRITE, 6'd0, 15'h7FFF, 4'($urandom), 8'($urandom), 1'($urandom));
    push_txn(OP_WRITE, 6'd63, 15'h7FFF, 4'($urandom), 8'($urandom), 1'($urandom));
    push_txn(OP_WRITE, 6'd31, 15'h5555, 4'($urandom), 8'($urandom), 1'($urandom));
    push_txn(OP_WRITE, 6'd32, 15'h2AAA, 4'($urandom), 8'($urandom), 1'($urandom));
    push_txn(OP_SET_LEVEL, 6'($urandom), 15'($urandom), 4'd0, 8'($urandom), 1'($urandom));
    tag_hold = 1'b1;
    push_txn(OP_SET_LEVEL, 6'($urandom), 15'($urandom), 4'd15, 8'($urandom), 1'($urandom));
    push_txn(OP_SET_LEVEL, 6'($urandom), 15'($urandom), 4'd9, 8'($urandom), 1'($urandom));
    tag_drain = 1'b1;
    push_txn(OP_FADE_OUT, 6'($urandom), 15'($urandom), 4'($urandom), 8'd0, 1'b1);
    repeat (3) push_rand(OP_TICK);
    push_rand(OP_WRITE);
    push_txn(OP_FADE_IN, 6'($urandom), 15'($urandom), 4'($urandom), 8'd2, 1'b0);
    repeat (3) push_rand(OP_TICK);
    push_txn(OP_SET_LEVEL, 6'($urandom), 15'($urandom), 4'd4, 8'($urandom), 1'($urandom));
    push_rand(OP_TICK);
    push_txn(OP_FADE_IN, 6'($urandom), 15'($urandom), 4'($urandom), 8'd255, 1'b1);
    repeat (2) push_rand(OP_TICK);

    // random part: mostly complete fades with writes mixed in
    while (pending_txns.size() < TARGET_ITEMS) begin
      tag_calm = (pending_txns.size() >= TARGET_ITEMS - CALM_ITEMS);
      tag_drain = !tag_calm && ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        nw = $urandom_range(0, 3);
        repeat (nw) push_rand(OP_WRITE);
        fps_pick = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(3, 255))
                                               : 8'($urandom_range(0, 2));
        push_txn($urandom_range(0, 1) ? OP_FADE_OUT : OP_FADE_IN, 6'($urandom),
                 15'($urandom), 4'($urandom), fps_pick, 1'($urandom));
        nt = 8 * ((fps_pick == 8'd0) ? 1 : int'(fps_pick)) + $urandom_range(0, 2);
        if (nt > 20) nt = 20;
        for (int i = 0; i < nt; i++) begin
          push_rand(OP_TICK);
          if ($urandom_range(0, 4) == 0) push_rand(OP_WRITE);
        end
      end else if (kind <= 7) begin
        nw = $urandom_range(0, 2);
        repeat (nw) push_rand(OP_WRITE);
        push_rand(OP_SET_LEVEL);
      end else begin
        nw = $urandom_range(1, 4);
        repeat (nw) push_rand(3'($urandom));
      end
    end
    tag_drain = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_txns.size() == 0 && !in_valid_i && expected_entries.size() == 0))
      @(posedge clk_i);
    repeat (END_DRAIN) @(posedge clk_i);

    $display("Run covered %0d input transactions and %0d checked entries in %0d apply runs.",
             n_items_in, n_results, n_runs);
    $display("Fades in and out to black and white, level saturation, restarts, cancels, stalls.");
    if (n_errors == 0 && expected_entries.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
